>>> sv/msw_pkg.sv
// Shared types and constants for the maximum sum of three windows block.
// Used by the RAM wrapper users, the controller, the datapath and the top level.
`default_nettype none

package msw_pkg;

  localparam int MAX_LEN  = 16384;
  localparam int ADDR_W   = $clog2(MAX_LEN);
  localparam int CNT_W    = ADDR_W + 1;
  localparam int SAMPLE_W = 16;
  localparam int K_W      = 13;
  localparam int WS_W     = 29;
  localparam int SUM_W    = 30;
  localparam int START_W  = 14;
  localparam int STATUS_W = 2;

  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_TOO_FEW  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_value;
    logic                last;
  } in_item_t;

  typedef struct packed {
    logic [START_W-1:0]  first_start;
    logic [START_W-1:0]  second_start;
    logic [START_W-1:0]  third_start;
    logic [SUM_W-1:0]    total_sum;
    logic [STATUS_W-1:0] status;
  } out_item_t;

  // One entry of the best-total tables: total plus a flag that it exists.
  typedef struct packed {
    logic             valid;
    logic [SUM_W-1:0] value;
  } best_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_CHECK,
    OP_WSUM,
    OP_BACK,
    OP_PICK,
    OP_EMIT
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic last_xfer;
    logic bad;
    logic wsum_done;
    logic back_done;
    logic pick_done;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

>>> sv/max_sum_three_windows_unit.sv
// Top level of the maximum sum of three windows block.
// Depends on msw_pkg, msw_ctrl, msw_dpath (and msw_ram inside the datapath).
`default_nettype none

// Samples stream in at one per cycle while the block loads, until the one marked last;
// each is added to a running prefix sum that is written to the store. The marked sample
// starts the solve: a check step, then three passes whose steps each take a registered
// RAM read in an A state, then compute and write in a B state: window sums over
// m = n - window_len + 1 positions, the backward fill of the one-, two- and
// three-window tables over the same m positions, and the forward pick, at most m
// steps. Too few samples or a set beyond 16384 samples skips the passes and goes
// from the check step straight to emit to report its status. Input is held off
// during the solve; a finished result waits in the output register while the next
// set loads. The RAMs need no clearing after reset: every entry whose value is used
// was written earlier for the same data set.
module max_sum_three_windows_unit (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [msw_pkg::K_W-1:0] cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  msw_pkg::in_item_t       in_item,
  output logic                    out_valid,
  input  logic                    out_ready,
  output msw_pkg::out_item_t      out_item
);

  msw_pkg::cmd_t cmd;
  msw_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  msw_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  msw_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

`default_nettype wire

>>> sv/msw_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module msw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AddrW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AddrW-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> sv/msw_ctrl.sv
// Sequencer for load, check, window sum, backward fill, forward pick and emit.
// Depends on msw_pkg for the command and status structs.
`default_nettype none

module msw_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  msw_pkg::sts_t sts,
  output msw_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    S_LOAD,
    S_CHECK,
    S_WSUM_A,
    S_WSUM_B,
    S_BACK_A,
    S_BACK_B,
    S_PICK_A,
    S_PICK_B,
    S_EMIT
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      unique case (state)
        S_LOAD:   if (sts.last_xfer) state <= S_CHECK;
        S_CHECK:  state <= sts.bad ? S_EMIT : S_WSUM_A;
        S_WSUM_A: state <= S_WSUM_B;
        S_WSUM_B: state <= sts.wsum_done ? S_BACK_A : S_WSUM_A;
        S_BACK_A: state <= S_BACK_B;
        S_BACK_B: state <= sts.back_done ? S_PICK_A : S_BACK_A;
        S_PICK_A: state <= S_PICK_B;
        S_PICK_B: state <= sts.pick_done ? S_EMIT : S_PICK_A;
        S_EMIT:   if (sts.out_free) state <= S_LOAD;
        default:  state <= S_LOAD;
      endcase
    end
  end

  // The A states only present read addresses; the datapath acts in the B states.
  always_comb begin
    cmd.op = msw_pkg::OP_NONE;
    unique case (state)
      S_LOAD:   cmd.op = msw_pkg::OP_LOAD;
      S_CHECK:  cmd.op = msw_pkg::OP_CHECK;
      S_WSUM_B: cmd.op = msw_pkg::OP_WSUM;
      S_BACK_B: cmd.op = msw_pkg::OP_BACK;
      S_PICK_B: cmd.op = msw_pkg::OP_PICK;
      S_EMIT:   cmd.op = sts.out_free ? msw_pkg::OP_EMIT : msw_pkg::OP_NONE;
      default:  cmd.op = msw_pkg::OP_NONE;
    endcase
  end

`ifndef SYNTHESIS
  a_check_after_last: assert property (@(posedge clk) disable iff (rst)
    state == S_CHECK |-> $past(sts.last_xfer))
    else $error("check entered without a final sample transfer");
`endif

endmodule

`default_nettype wire

>>> sv/msw_dpath.sv
// Datapath: prefix store, window sums, best-total tables, pick logic, result register.
// Depends on msw_pkg and msw_ram.
`default_nettype none

module msw_dpath (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  input  logic [msw_pkg::K_W-1:0] cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  msw_pkg::in_item_t       in_item,
  output logic                    out_valid,
  input  logic                    out_ready,
  output msw_pkg::out_item_t      out_item,
  input  msw_pkg::cmd_t           cmd,
  output msw_pkg::sts_t           sts
);

  localparam int AW = msw_pkg::ADDR_W;
  localparam int CW = msw_pkg::CNT_W;
  localparam int SW = msw_pkg::SUM_W;
  localparam int BW = $bits(msw_pkg::best_t);

  // control registers
  logic [msw_pkg::K_W-1:0] window_len;
  logic [CW-1:0]           count;
  logic [SW-1:0]           prefix;
  logic                    ovf;

  // working registers
  logic [msw_pkg::K_W-1:0]      k;
  logic [CW-1:0]                m;
  logic [CW-1:0]                cnt;
  logic [1:0]                   rem;
  msw_pkg::best_t               skip1, skip2, skip3;
  logic [msw_pkg::START_W-1:0]  start0, start1, start2;
  logic [msw_pkg::STATUS_W-1:0] status_r;

  logic                load_xfer, store_ok;
  logic [SW-1:0]       pre_next;
  logic [CW-1:0]       three_k, addr_k, addr_1, pa_full, pb_full;
  logic                nxt_ok, one_ok;
  logic [SW-1:0]       pa_rdata, pb_rdata, ws_diff, ws_ext;
  logic [msw_pkg::WS_W-1:0] ws_rdata;
  logic [BW-1:0]       b1_rdata, b2_rdata, b3_rdata;
  msw_pkg::best_t      b1_q, b2_q, b3_q;
  msw_pkg::best_t      new1, new2, new3;
  logic [SW-1:0]       t2, t3;
  logic                tok2, tok3;
  msw_pkg::best_t      rest, cur;
  logic [SW-1:0]       tp;
  logic                tokp, sokp, takep;
  logic [1:0]          rem_next;
  logic [CW-1:0]       pos_next;
  logic [AW-1:0]       b1_raddr, b2_raddr;

  assign in_ready  = (cmd.op == msw_pkg::OP_LOAD);
  assign load_xfer = in_valid && in_ready;
  assign store_ok  = (count < CW'(msw_pkg::MAX_LEN));
  assign pre_next  = prefix + SW'(in_item.sample_value);

  assign three_k = CW'(k) + CW'({k, 1'b0});
  assign addr_k  = cnt + CW'(k);
  assign addr_1  = cnt + CW'(1);
  assign pa_full = addr_k - CW'(1);
  assign pb_full = cnt - CW'(1);
  assign nxt_ok  = (addr_k < m);
  assign one_ok  = (addr_1 < m);

  // Prefix store: entry i holds the sum of samples 0..i. Two copies give two reads.
  msw_ram #(.WIDTH(SW), .DEPTH(msw_pkg::MAX_LEN)) u_pre_a (
    .clk(clk), .we(load_xfer && store_ok), .waddr(count[AW-1:0]), .wdata(pre_next),
    .raddr(pa_full[AW-1:0]), .rdata(pa_rdata)
  );

  msw_ram #(.WIDTH(SW), .DEPTH(msw_pkg::MAX_LEN)) u_pre_b (
    .clk(clk), .we(load_xfer && store_ok), .waddr(count[AW-1:0]), .wdata(pre_next),
    .raddr(pb_full[AW-1:0]), .rdata(pb_rdata)
  );

  assign ws_diff = pa_rdata - ((cnt == '0) ? '0 : pb_rdata);

  msw_ram #(.WIDTH(msw_pkg::WS_W), .DEPTH(msw_pkg::MAX_LEN)) u_wsum (
    .clk(clk), .we(cmd.op == msw_pkg::OP_WSUM), .waddr(cnt[AW-1:0]),
    .wdata(ws_diff[msw_pkg::WS_W-1:0]), .raddr(cnt[AW-1:0]), .rdata(ws_rdata)
  );

  assign ws_ext = SW'(ws_rdata);

  // During the backward fill rem holds 3, so tables one and two read at i+k.
  assign b1_raddr = (rem == 2'd1) ? addr_1[AW-1:0] : addr_k[AW-1:0];
  assign b2_raddr = (rem == 2'd2) ? addr_1[AW-1:0] : addr_k[AW-1:0];

  msw_ram #(.WIDTH(BW), .DEPTH(msw_pkg::MAX_LEN)) u_best1 (
    .clk(clk), .we(cmd.op == msw_pkg::OP_BACK), .waddr(cnt[AW-1:0]), .wdata(new1),
    .raddr(b1_raddr), .rdata(b1_rdata)
  );

  msw_ram #(.WIDTH(BW), .DEPTH(msw_pkg::MAX_LEN)) u_best2 (
    .clk(clk), .we(cmd.op == msw_pkg::OP_BACK), .waddr(cnt[AW-1:0]), .wdata(new2),
    .raddr(b2_raddr), .rdata(b2_rdata)
  );

  msw_ram #(.WIDTH(BW), .DEPTH(msw_pkg::MAX_LEN)) u_best3 (
    .clk(clk), .we(cmd.op == msw_pkg::OP_BACK), .waddr(cnt[AW-1:0]), .wdata(new3),
    .raddr(addr_1[AW-1:0]), .rdata(b3_rdata)
  );

  assign b1_q = msw_pkg::best_t'(b1_rdata);
  assign b2_q = msw_pkg::best_t'(b2_rdata);
  assign b3_q = msw_pkg::best_t'(b3_rdata);

  // Backward fill: take the window at i, or skip to the best from i+1 (held in skipN).
  always_comb begin
    t2   = ws_ext + b1_q.value;
    t3   = ws_ext + b2_q.value;
    tok2 = nxt_ok && b1_q.valid;
    tok3 = nxt_ok && b2_q.valid;

    if (!skip1.valid || ws_ext >= skip1.value) begin
      new1 = '{valid: 1'b1, value: ws_ext};
    end else begin
      new1 = skip1;
    end

    if (tok2 && (!skip2.valid || t2 >= skip2.value)) begin
      new2 = '{valid: 1'b1, value: t2};
    end else begin
      new2 = skip2;
    end

    if (tok3 && (!skip3.valid || t3 >= skip3.value)) begin
      new3 = '{valid: 1'b1, value: t3};
    end else begin
      new3 = skip3;
    end
  end

  // Forward pick: compare taking the window at pos with skipping it.
  always_comb begin
    unique case (rem)
      2'd1: begin
        rest = '0;
        cur  = b1_q;
      end
      2'd2: begin
        rest = b1_q;
        cur  = b2_q;
      end
      default: begin
        rest = b2_q;
        cur  = b3_q;
      end
    endcase
    tp       = ws_ext + rest.value;
    tokp     = (rem == 2'd1) || (nxt_ok && rest.valid);
    sokp     = one_ok && cur.valid;
    takep    = tokp && (!sokp || tp >= cur.value);
    rem_next = takep ? rem - 2'd1 : rem;
    pos_next = takep ? addr_k : addr_1;
  end

  assign sts.last_xfer = load_xfer && in_item.last;
  assign sts.bad       = ovf || (count < three_k);
  assign sts.wsum_done = (addr_1 == m);
  assign sts.back_done = (cnt == '0);
  assign sts.pick_done = (rem_next == 2'd0) || (pos_next >= m);
  assign sts.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_len <= msw_pkg::K_W'(1);
      count      <= '0;
      prefix     <= '0;
      ovf        <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        window_len <= cfg_data;
      end
      if (cmd.op == msw_pkg::OP_EMIT) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (load_xfer) begin
        if (store_ok) begin
          count  <= count + CW'(1);
          prefix <= pre_next;
        end else begin
          ovf <= 1'b1;
        end
      end
      if (cmd.op == msw_pkg::OP_EMIT) begin
        count     <= '0;
        prefix    <= '0;
        ovf       <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      msw_pkg::OP_LOAD: begin
        if (load_xfer && in_item.last) begin
          k <= (window_len == '0) ? msw_pkg::K_W'(1) : window_len;
        end
      end
      msw_pkg::OP_CHECK: begin
        if (ovf) begin
          status_r <= msw_pkg::STATUS_OVERFLOW;
        end else if (count < three_k) begin
          status_r <= msw_pkg::STATUS_TOO_FEW;
        end else begin
          status_r <= msw_pkg::STATUS_OK;
        end
        m      <= count - CW'(k) + CW'(1);
        cnt    <= '0;
        rem    <= 2'd3;
        skip1  <= '0;
        skip2  <= '0;
        skip3  <= '0;
        start0 <= '0;
        start1 <= '0;
        start2 <= '0;
      end
      msw_pkg::OP_WSUM: begin
        // hold the counter on the last position: the backward fill starts there
        if (!sts.wsum_done) cnt <= addr_1;
      end
      msw_pkg::OP_BACK: begin
        skip1 <= new1;
        skip2 <= new2;
        skip3 <= new3;
        if (cnt != '0) cnt <= pb_full;
      end
      msw_pkg::OP_PICK: begin
        if (takep) begin
          unique case (rem)
            2'd3:    start0 <= cnt[msw_pkg::START_W-1:0];
            2'd2:    start1 <= cnt[msw_pkg::START_W-1:0];
            default: start2 <= cnt[msw_pkg::START_W-1:0];
          endcase
        end
        rem <= rem_next;
        cnt <= pos_next;
      end
      msw_pkg::OP_EMIT: begin
        out_item.status <= status_r;
        if (status_r == msw_pkg::STATUS_OK) begin
          out_item.first_start  <= start0;
          out_item.second_start <= start1;
          out_item.third_start  <= start2;
          out_item.total_sum    <= skip3.value;
        end else begin
          out_item.first_start  <= '0;
          out_item.second_start <= '0;
          out_item.third_start  <= '0;
          out_item.total_sum    <= '0;
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.op == msw_pkg::OP_EMIT |-> (!out_valid || out_ready))
    else $error("result register overwritten while a transfer is pending");

  a_back_range: assert property (@(posedge clk) disable iff (rst)
    cmd.op == msw_pkg::OP_BACK |-> cnt < m)
    else $error("backward fill position outside the window range");

  a_three_picked: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == msw_pkg::OP_EMIT && status_r == msw_pkg::STATUS_OK) |-> rem == 2'd0)
    else $error("forward pick ended with fewer than three windows");
`endif

endmodule

`default_nettype wire
